/* design/jacobi_five_point_stencil_macros.svh */
// Assertion macros shared by the design files.
// The enclosing module must have signals named clk and rst_n.
`ifndef JACOBI_FIVE_POINT_STENCIL_MACROS_SVH
`define JACOBI_FIVE_POINT_STENCIL_MACROS_SVH

`ifndef ASSERT_OFF

`define JFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define JFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define JFS_ASSERT_IMP(lbl, ante, cons, msg)

`define JFS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

/* design/jfs_pkg.sv */
package jfs_pkg;

  localparam int DATA_W  = 32;
  localparam int SUM_W   = 35;
  localparam int PROD_W  = 50;
  localparam int CFG_W   = 16;
  localparam int STEPS_W = 16;
  localparam int GSIZE_W = 7;
  localparam int ROWC_W  = 6;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic CFG_TIME_STEPS = 1'b0;
  localparam logic CFG_GRID_SIZE  = 1'b1;

  localparam logic [STEPS_W-1:0] TIME_STEPS_RST = 16'd1;
  localparam logic [GSIZE_W-1:0] GRID_SIZE_RST  = 7'd64;

  // neighbor fetch order within one element
  localparam logic [2:0] NBR_CENTER = 3'd0;
  localparam logic [2:0] NBR_LEFT   = 3'd1;
  localparam logic [2:0] NBR_RIGHT  = 3'd2;
  localparam logic [2:0] NBR_UP     = 3'd3;
  localparam logic [2:0] NBR_DOWN   = 3'd4;

  // 0.2 in Q0.16, rounding bias for the >>16
  localparam logic signed [14:0] FIFTH_Q16  = 15'sd13107;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = 50'sd32768;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP_CHK,
    ST_RD,
    ST_ACC,
    ST_MUL,
    ST_WR,
    ST_SWEEP_END
  } state_t;

  typedef struct packed {
    logic cfg_open;
    logic accept;
    logic load_steps;
    logic dec_steps;
    logic toggle_bank;
    logic init_pos;
    logic rd_issue;
    logic mul;
    logic wr_result;
    logic advance_pos;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pipe_free;
    logic steps_zero;
    logic no_interior;
    logic phase_last;
    logic row_last;
    logic col_last;
  } dp_stat_t;

endpackage

/* design/jfs_bank.sv */
module jfs_bank #(
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [jfs_pkg::DATA_W-1:0]  wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [jfs_pkg::DATA_W-1:0]  rdata
);
  import jfs_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/jfs_ctrl.sv */
`include "jacobi_five_point_stencil_macros.svh"

module jfs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_command,
  input  jfs_pkg::dp_stat_t   stat,
  output jfs_pkg::ctrl_cmd_t  cmd,
  output logic                in_stall
);
  import jfs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && stat.pipe_free && in_command == CMD_RUN) begin
          state_nxt = ST_STEP_CHK;
        end
      end
      ST_STEP_CHK: begin
        if (stat.steps_zero) begin
          state_nxt = ST_IDLE;
        end else if (!stat.no_interior) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        if (stat.phase_last) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_WR;
      ST_WR: begin
        if (stat.row_last && stat.col_last) begin
          state_nxt = ST_SWEEP_END;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_SWEEP_END: state_nxt = ST_STEP_CHK;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        cmd.cfg_open   = 1'b1;
        in_stall       = !stat.pipe_free;
        cmd.accept     = in_valid && stat.pipe_free;
        cmd.load_steps = in_valid && stat.pipe_free && in_command == CMD_RUN;
      end
      ST_STEP_CHK: begin
        // a grid without interior still swaps banks once per sweep
        if (!stat.steps_zero && stat.no_interior) begin
          cmd.dec_steps   = 1'b1;
          cmd.toggle_bank = 1'b1;
        end
        if (!stat.steps_zero && !stat.no_interior) begin
          cmd.init_pos = 1'b1;
        end
      end
      ST_RD:  cmd.rd_issue = 1'b1;
      ST_ACC: cmd = '0;
      ST_MUL: cmd.mul = 1'b1;
      ST_WR: begin
        cmd.wr_result   = 1'b1;
        cmd.advance_pos = 1'b1;
      end
      ST_SWEEP_END: begin
        cmd.dec_steps   = 1'b1;
        cmd.toggle_bank = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  `JFS_ASSERT_IMP(a_accept_idle, cmd.accept, state_r == ST_IDLE, "request taken during run")
  `JFS_ASSERT_NXT(a_run_starts, cmd.load_steps, state_r == ST_STEP_CHK, "run did not start")
  `JFS_ASSERT_IMP(a_one_sweep_op, cmd.rd_issue || cmd.mul || cmd.wr_result,
                  !cmd.accept && !cmd.cfg_open, "sweep overlaps host access")

endmodule

/* design/jfs_dp.sv */
`include "jacobi_five_point_stencil_macros.svh"

module jfs_dp #(
  parameter int GRID_SIDE = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  jfs_pkg::ctrl_cmd_t                  cmd,
  output jfs_pkg::dp_stat_t                   stat,
  input  logic [1:0]                          in_command,
  input  logic [jfs_pkg::ROWC_W-1:0]          in_row,
  input  logic [jfs_pkg::ROWC_W-1:0]          in_column,
  input  logic signed [jfs_pkg::DATA_W-1:0]   in_write_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [jfs_pkg::DATA_W-1:0]   out_read_value,
  output logic                                out_status,
  input  logic                                cfg_valid,
  input  logic                                cfg_index,
  input  logic [jfs_pkg::CFG_W-1:0]           cfg_wdata
);
  import jfs_pkg::*;

  localparam int DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(GRID_SIDE);
  localparam int NW    = $clog2(GRID_SIDE + 1);
  localparam logic [AW-1:0] SIDE_A = AW'(GRID_SIDE);

  // configuration
  logic [STEPS_W-1:0] time_steps_r;
  logic [GSIZE_W-1:0] grid_size_r;
  logic               cfg_we;

  assign cfg_we = cfg_valid && cmd.cfg_open;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_steps_r <= TIME_STEPS_RST;
      grid_size_r  <= GRID_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIME_STEPS: time_steps_r <= cfg_wdata;
        CFG_GRID_SIZE:  grid_size_r  <= cfg_wdata[GSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [NW-1:0] n_eff;
  logic [NW-1:0] n_m2;
  logic          in_grid;

  assign n_eff   = (int'(grid_size_r) > GRID_SIDE) ? NW'(GRID_SIDE) : NW'(grid_size_r);
  assign n_m2    = n_eff - NW'(2);
  assign in_grid = (int'(in_row) < int'(n_eff)) && (int'(in_column) < int'(n_eff));

  // sweep counters
  logic [STEPS_W-1:0] steps_r, steps_nxt;
  logic [CW-1:0]      r_r, r_nxt, c_r, c_nxt;
  logic [2:0]         k_r, k_nxt;
  logic               bank_r;

  always_comb begin
    steps_nxt = steps_r;
    if (cmd.load_steps) begin
      steps_nxt = time_steps_r;
    end else if (cmd.dec_steps) begin
      steps_nxt = steps_r - STEPS_W'(1);
    end
  end

  always_comb begin
    r_nxt = r_r;
    c_nxt = c_r;
    k_nxt = k_r;
    if (cmd.init_pos) begin
      r_nxt = CW'(1);
      c_nxt = CW'(1);
      k_nxt = NBR_CENTER;
    end else if (cmd.advance_pos) begin
      k_nxt = NBR_CENTER;
      if (NW'(c_r) == n_m2) begin
        c_nxt = CW'(1);
        r_nxt = r_r + CW'(1);
      end else begin
        c_nxt = c_r + CW'(1);
      end
    end else if (cmd.rd_issue) begin
      k_nxt = k_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= '0;
      r_r     <= CW'(1);
      c_r     <= CW'(1);
      k_r     <= NBR_CENTER;
      bank_r  <= 1'b0;
    end else begin
      steps_r <= steps_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      k_r     <= k_nxt;
      if (cmd.toggle_bank) begin
        bank_r <= !bank_r;
      end
    end
  end

  assign stat.steps_zero  = steps_r == '0;
  assign stat.no_interior = n_eff < NW'(3);
  assign stat.phase_last  = k_r == NBR_DOWN;
  assign stat.row_last    = NW'(r_r) == n_m2;
  assign stat.col_last    = NW'(c_r) == n_m2;

  // addresses
  logic [AW-1:0] pos_addr, nbr_addr, host_addr;

  assign pos_addr  = AW'(r_r) * SIDE_A + AW'(c_r);
  assign host_addr = AW'(in_row) * SIDE_A + AW'(in_column);

  always_comb begin
    case (k_r)
      NBR_CENTER: nbr_addr = pos_addr;
      NBR_LEFT:   nbr_addr = pos_addr - AW'(1);
      NBR_RIGHT:  nbr_addr = pos_addr + AW'(1);
      NBR_UP:     nbr_addr = pos_addr - SIDE_A;
      NBR_DOWN:   nbr_addr = pos_addr + SIDE_A;
      default:    nbr_addr = pos_addr;
    endcase
  end

  // banks
  logic              host_we, host_re, bank_re;
  logic [1:0]        bank_we;
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] rdata0, rdata1;
  logic signed [PROD_W-1:0] rounded;
  logic signed [DATA_W-1:0] fifth;

  assign host_we = cmd.accept && in_command == CMD_WRITE && in_grid;
  assign host_re = cmd.accept && in_command == CMD_READ;
  assign bank_re = host_re || cmd.rd_issue;
  // host writes go to both banks; sweep results go to the bank not being read
  assign bank_we[0] = host_we || (cmd.wr_result && bank_r);
  assign bank_we[1] = host_we || (cmd.wr_result && !bank_r);
  assign waddr   = cmd.wr_result ? pos_addr : host_addr;
  assign raddr   = cmd.rd_issue ? nbr_addr : host_addr;
  assign wdata   = cmd.wr_result ? fifth : in_write_value;

  jfs_bank #(.DEPTH(DEPTH)) u_bank0 (
    .clk   (clk),
    .we    (bank_we[0]),
    .waddr (waddr),
    .wdata (wdata),
    .re    (bank_re),
    .raddr (raddr),
    .rdata (rdata0)
  );

  jfs_bank #(.DEPTH(DEPTH)) u_bank1 (
    .clk   (clk),
    .we    (bank_we[1]),
    .waddr (waddr),
    .wdata (wdata),
    .re    (bank_re),
    .raddr (raddr),
    .rdata (rdata1)
  );

  // stencil arithmetic
  logic signed [DATA_W-1:0] src_word;
  logic                     rd_d1_r;
  logic [2:0]               k_d1_r;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [PROD_W-1:0] prod_r;

  assign src_word = bank_r ? rdata1 : rdata0;
  assign sum_nxt  = ((k_d1_r == NBR_CENTER) ? SUM_W'(0) : sum_r) + SUM_W'(src_word);
  assign rounded  = prod_r + ROUND_HALF;
  assign fifth    = rounded[DATA_W+15:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_d1_r <= 1'b0;
    end else begin
      rd_d1_r <= cmd.rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    k_d1_r <= k_r;
    if (rd_d1_r) begin
      sum_r <= sum_nxt;
    end
    if (cmd.mul) begin
      prod_r <= sum_r * FIFTH_Q16;
    end
  end

  // response path: a stage beside the bank read register, then the output register
  logic s1_valid_r, s1_is_read_r, s1_status_r, s1_bank_r;
  logic s1_adv;
  logic out_valid_r;
  logic signed [DATA_W-1:0] out_read_value_r;
  logic out_status_r;

  assign s1_adv         = s1_valid_r && (!out_valid_r || !out_stall);
  assign stat.pipe_free = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s1_is_read_r <= in_command == CMD_READ && in_grid;
      s1_status_r  <= (in_command == CMD_WRITE || in_command == CMD_READ) && !in_grid;
      s1_bank_r    <= bank_r;
    end
    if (s1_adv) begin
      out_read_value_r <= s1_is_read_r ? (s1_bank_r ? rdata1 : rdata0) : '0;
      out_status_r     <= s1_status_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;

  `JFS_ASSERT_NXT(a_s1_holds, s1_valid_r && out_valid_r && out_stall, s1_valid_r,
                  "pending response dropped")
  `JFS_ASSERT_NXT(a_out_from_s1, !out_valid_r && !s1_valid_r, !out_valid_r,
                  "response without request")
  `JFS_ASSERT_IMP(a_sweep_wr_one_bank, cmd.wr_result, bank_we[0] != bank_we[1],
                  "sweep result written to both banks")

endmodule

/* design/jacobi_five_point_stencil.sv */
// Channel  Handshake            Payload
// in       in_valid / in_stall  in_command, in_row, in_column, in_write_value
// out      out_valid/out_stall  out_read_value, out_status
// cfg      cfg_valid/cfg_ready  cfg_index, cfg_wdata
//
// Write, read and unknown requests are taken one per cycle while the response
// stage can advance; a read answers via the bank read register and response stage.
// A run is answered like any other request and holds in_stall until its time
// steps are done, one sweep per step (a bank swap alone when n < 3):
// each interior element takes five reads on the single bank read port,
// one accumulate, one multiply and one write.
// rst_n is synchronous; the grid banks are not cleared and hold garbage until written.
// out_stall back-pressures through the response stage into in_stall.
module jacobi_five_point_stencil #(
  parameter int GRID_SIDE = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_command,
  input  logic [jfs_pkg::ROWC_W-1:0]          in_row,
  input  logic [jfs_pkg::ROWC_W-1:0]          in_column,
  input  logic signed [jfs_pkg::DATA_W-1:0]   in_write_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [jfs_pkg::DATA_W-1:0]   out_read_value,
  output logic                                out_status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [jfs_pkg::CFG_W-1:0]           cfg_wdata
);
  import jfs_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  jfs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd),
    .in_stall   (in_stall)
  );

  jfs_dp #(.GRID_SIDE(GRID_SIDE)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_command     (in_command),
    .in_row         (in_row),
    .in_column      (in_column),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  assign cfg_ready = cmd.cfg_open;

endmodule
